### rtl/core/trscc_pkg.sv
// ----------------------------------------------------------------------------
// trscc_pkg
// Shared types and constants for the two-register stack processor core:
// memory geometry, opcode and halt-cause codes, controller states, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package trscc_pkg;

    // Memory geometry. The depth is a power of two, so address wrap is a
    // plain truncation of the two's complement sum.
    localparam int unsigned MEM_WORDS = 16384;
    localparam int unsigned ADDR_W    = $clog2(MEM_WORDS);
    localparam int unsigned WORD_W    = 32;

    // Item kinds carried on the input tuser bit.
    localparam logic ITEM_WRITE = 1'b0;
    localparam logic ITEM_STEP  = 1'b1;

    // Opcodes, as the low byte of an instruction word.
    localparam logic [7:0] OPC_LDC    = 8'd0;
    localparam logic [7:0] OPC_ADC    = 8'd1;
    localparam logic [7:0] OPC_LDL    = 8'd2;
    localparam logic [7:0] OPC_STL    = 8'd3;
    localparam logic [7:0] OPC_LDNL   = 8'd4;
    localparam logic [7:0] OPC_STNL   = 8'd5;
    localparam logic [7:0] OPC_ADD    = 8'd6;
    localparam logic [7:0] OPC_SUB    = 8'd7;
    localparam logic [7:0] OPC_SHL    = 8'd8;
    localparam logic [7:0] OPC_SHR    = 8'd9;
    localparam logic [7:0] OPC_ADJ    = 8'd10;
    localparam logic [7:0] OPC_A2SP   = 8'd11;
    localparam logic [7:0] OPC_SP2A   = 8'd12;
    localparam logic [7:0] OPC_CALL   = 8'd13;
    localparam logic [7:0] OPC_RETURN = 8'd14;
    localparam logic [7:0] OPC_BRZ    = 8'd15;
    localparam logic [7:0] OPC_BRLZ   = 8'd16;
    localparam logic [7:0] OPC_BR     = 8'd17;
    localparam logic [7:0] OPC_HALT   = 8'd18;
    localparam logic [7:0] OPC_DATA   = 8'hFF;
    localparam logic [7:0] OPC_SET    = 8'hFE;
    localparam logic [7:0] OPC_NONE   = 8'h00;

    // Halt causes.
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_HALTOP   = 3'd1;
    localparam logic [2:0] CAUSE_SELFRET  = 3'd2;
    localparam logic [2:0] CAUSE_UNKNOWN  = 3'd3;
    localparam logic [2:0] CAUSE_SPOVER   = 3'd4;
    localparam logic [2:0] CAUSE_SELFLOOP = 3'd5;

    // Bit positions of the result fields in the output tdata.
    localparam int unsigned OUT_PC_LSB    = 0;
    localparam int unsigned OUT_SP_LSB    = 32;
    localparam int unsigned OUT_A_LSB     = 64;
    localparam int unsigned OUT_B_LSB     = 96;
    localparam int unsigned OUT_OPC_LSB   = 128;
    localparam int unsigned OUT_HALT_BIT  = 136;
    localparam int unsigned OUT_CAUSE_LSB = 137;
    localparam int unsigned OUT_TDATA_W   = 144;
    localparam int unsigned IN_TDATA_W    = 48;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_REPORT
    } t_state;

    // Memory address source.
    typedef enum logic [1:0] {
        MS_CLEAR,
        MS_INPUT,
        MS_PC,
        MS_DATA
    } t_mem_sel;

    // Controller to datapath commands.
    typedef struct packed {
        t_mem_sel mem_sel;
        logic     mem_we;
        logic     mem_re;
        logic     clr_step;
        logic     latch_instr;
        logic     commit;
        logic     load_out;
        logic     report;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic stopped;
        logic is_store;
        logic clear_last;
    } t_dp_status;

endpackage

### rtl/core/trscc_ram.sv
// ----------------------------------------------------------------------------
// trscc_ram
// Generic single-port RAM with a registered read. A write and a read are
// never issued together; read data holds until the next read.
// ----------------------------------------------------------------------------
module trscc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/trscc_dpath.sv
// ----------------------------------------------------------------------------
// trscc_dpath
// Datapath: architectural registers, instruction register, memory address
// and data selection, the execute logic and the result register.
// ----------------------------------------------------------------------------
module trscc_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  trscc_pkg::t_dp_cmd      i_cmd,
    output trscc_pkg::t_dp_status   o_status,
    input  logic [13:0]             i_wr_addr,
    input  logic [31:0]             i_wr_data,
    output logic [31:0]             o_pc,
    output logic [31:0]             o_sp,
    output logic [31:0]             o_acc_a,
    output logic [31:0]             o_acc_b,
    output logic [7:0]              o_opcode_done,
    output logic                    o_halted,
    output logic [2:0]              o_halt_cause
);

    import trscc_pkg::*;

    // Architectural state.
    logic [31:0]       r_pc, r_sp, r_a, r_b;
    logic              r_stopped;
    logic [2:0]        r_cause;
    logic [31:0]       r_instr;
    logic [ADDR_W-1:0] r_clr_addr;

    // Result register.
    logic [31:0] r_out_pc, r_out_sp, r_out_a, r_out_b;
    logic [7:0]  r_out_opc;
    logic        r_out_halted;
    logic [2:0]  r_out_cause;

    // Memory port.
    logic [ADDR_W-1:0] w_mem_addr;
    logic [31:0]       w_mem_wdata;
    logic [31:0]       w_mem_rdata;

    // Decode-cycle signals, taken straight from the fetched word.
    logic [7:0]        w_fetch_opc;
    logic [ADDR_W-1:0] w_dbase;
    logic [ADDR_W-1:0] w_daddr;
    logic [31:0]       w_dwdata;

    // Execute-cycle signals.
    logic [7:0]  w_opc;
    logic [31:0] w_opr;
    logic [31:0] w_pc_rel, w_pc_rel1, w_pc_inc, w_a_inc;
    logic [31:0] w_sh_right;
    logic [31:0] n_pc, n_sp, n_a, n_b;
    logic [31:0] w_pc_stop, w_pc_run;
    logic        w_branchy;
    logic [2:0]  w_base_cause;
    logic [2:0]  w_cause;

    // Data address and store data for loads and stores during decode.
    always_comb begin
        w_fetch_opc = w_mem_rdata[7:0];
        if (w_fetch_opc == OPC_LDL || w_fetch_opc == OPC_STL) begin
            w_dbase = r_sp[ADDR_W-1:0];
        end else begin
            w_dbase = r_a[ADDR_W-1:0];
        end
        w_daddr  = w_dbase + w_mem_rdata[8 +: ADDR_W];
        w_dwdata = (w_fetch_opc == OPC_STL) ? r_a : r_b;
    end

    // Memory address and write data selection.
    always_comb begin
        case (i_cmd.mem_sel)
            MS_CLEAR: begin
                w_mem_addr  = r_clr_addr;
                w_mem_wdata = '0;
            end
            MS_INPUT: begin
                w_mem_addr  = i_wr_addr[ADDR_W-1:0];
                w_mem_wdata = i_wr_data;
            end
            MS_PC: begin
                w_mem_addr  = r_pc[ADDR_W-1:0];
                w_mem_wdata = '0;
            end
            MS_DATA: begin
                w_mem_addr  = w_daddr;
                w_mem_wdata = w_dwdata;
            end
            default: begin
                w_mem_addr  = r_clr_addr;
                w_mem_wdata = '0;
            end
        endcase
    end

    trscc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_re    (i_cmd.mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // Status toward the controller.
    always_comb begin
        o_status.stopped    = r_stopped;
        o_status.is_store   = w_fetch_opc inside {OPC_STL, OPC_STNL};
        o_status.clear_last = (r_clr_addr == ADDR_W'(MEM_WORDS - 1));
    end

    // Operand, shift result and program counter candidates, all formed in parallel.
    always_comb begin
        w_opc      = r_instr[7:0];
        w_opr      = {{8{r_instr[31]}}, r_instr[31:8]};
        w_pc_rel   = r_pc + w_opr;
        w_pc_rel1  = r_pc + w_opr + 32'd1;
        w_pc_inc   = r_pc + 32'd1;
        w_a_inc    = r_a + 32'd1;
        w_sh_right = 32'($signed(r_b) >>> r_a[4:0]);
    end

    // Execute: next register values and the halt cause.
    always_comb begin
        n_a          = r_a;
        n_b          = r_b;
        n_sp         = r_sp;
        w_pc_stop    = r_pc;
        w_pc_run     = w_pc_inc;
        w_branchy    = 1'b0;
        w_base_cause = CAUSE_NONE;
        case (w_opc)
            OPC_LDC: begin
                n_b = r_a;
                n_a = w_opr;
            end
            OPC_ADC:  n_a = r_a + w_opr;
            OPC_LDL: begin
                n_b = r_a;
                n_a = w_mem_rdata;
            end
            OPC_STL:  n_a = r_b;
            OPC_LDNL: n_a = w_mem_rdata;
            OPC_STNL: n_a = r_a;
            OPC_ADD:  n_a = r_a + r_b;
            OPC_SUB:  n_a = r_b - r_a;
            OPC_SHL:  n_a = r_b << r_a[4:0];
            OPC_SHR:  n_a = w_sh_right;
            OPC_ADJ:  n_sp = r_sp + w_opr;
            OPC_A2SP: begin
                n_sp = r_a;
                n_a  = r_b;
            end
            OPC_SP2A: begin
                n_b = r_a;
                n_a = r_sp;
            end
            OPC_CALL: begin
                n_b       = r_a;
                n_a       = r_pc;
                w_pc_stop = w_pc_rel;
                w_pc_run  = w_pc_rel1;
                w_branchy = 1'b1;
            end
            OPC_RETURN: begin
                // A return to itself with both registers equal spins forever.
                if (r_pc == r_a && r_a == r_b) begin
                    w_base_cause = CAUSE_SELFRET;
                end
                n_a       = r_b;
                w_pc_stop = r_a;
                w_pc_run  = w_a_inc;
            end
            OPC_BRZ: begin
                if (r_a == 32'd0) begin
                    w_pc_stop = w_pc_rel;
                    w_pc_run  = w_pc_rel1;
                end
                w_branchy = 1'b1;
            end
            OPC_BRLZ: begin
                if (r_a[31]) begin
                    w_pc_stop = w_pc_rel;
                    w_pc_run  = w_pc_rel1;
                end
                w_branchy = 1'b1;
            end
            OPC_BR: begin
                w_pc_stop = w_pc_rel;
                w_pc_run  = w_pc_rel1;
                w_branchy = 1'b1;
            end
            OPC_HALT:           w_base_cause = CAUSE_HALTOP;
            OPC_DATA, OPC_SET:  n_a = r_a;
            default:            w_base_cause = CAUSE_UNKNOWN;
        endcase

        // Stack overflow comes after the opcode causes, self loop last.
        if (w_base_cause != CAUSE_NONE) begin
            w_cause = w_base_cause;
        end else if (!n_sp[31] && (|n_sp[30:ADDR_W])) begin
            w_cause = CAUSE_SPOVER;
        end else if (w_branchy && (&r_instr[31:8])) begin
            w_cause = CAUSE_SELFLOOP;
        end else begin
            w_cause = CAUSE_NONE;
        end

        n_pc = (w_cause == CAUSE_NONE) ? w_pc_run : w_pc_stop;
    end

    // Architectural registers and the clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_sp       <= 32'(MEM_WORDS - 1);
            r_a        <= '0;
            r_b        <= '0;
            r_stopped  <= 1'b0;
            r_cause    <= CAUSE_NONE;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.commit) begin
                r_pc <= n_pc;
                r_sp <= n_sp;
                r_a  <= n_a;
                r_b  <= n_b;
                if (w_cause != CAUSE_NONE) begin
                    r_stopped <= 1'b1;
                    r_cause   <= w_cause;
                end
            end
        end
    end

    // Instruction register and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_instr) begin
            r_instr <= w_mem_rdata;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.report) begin
                r_out_pc     <= r_pc;
                r_out_sp     <= r_sp;
                r_out_a      <= r_a;
                r_out_b      <= r_b;
                r_out_opc    <= OPC_NONE;
                r_out_halted <= r_stopped;
                r_out_cause  <= r_cause;
            end else begin
                r_out_pc     <= n_pc;
                r_out_sp     <= n_sp;
                r_out_a      <= n_a;
                r_out_b      <= n_b;
                r_out_opc    <= w_opc;
                r_out_halted <= (w_cause != CAUSE_NONE);
                r_out_cause  <= w_cause;
            end
        end
    end

    assign o_pc          = r_out_pc;
    assign o_sp          = r_out_sp;
    assign o_acc_a       = r_out_a;
    assign o_acc_b       = r_out_b;
    assign o_opcode_done = r_out_opc;
    assign o_halted      = r_out_halted;
    assign o_halt_cause  = r_out_cause;

endmodule

### rtl/core/trscc_ctrl.sv
// ----------------------------------------------------------------------------
// trscc_ctrl
// Controller: sequences the memory clearing pass, write items and the
// fetch, decode and execute cycles of a step, and owns both handshakes.
// ----------------------------------------------------------------------------
module trscc_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_kind,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output trscc_pkg::t_dp_cmd      o_cmd,
    input  trscc_pkg::t_dp_status   i_status
);

    import trscc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.mem_sel = MS_CLEAR;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == ITEM_WRITE) begin
                        o_cmd.mem_sel = MS_INPUT;
                        o_cmd.mem_we  = 1'b1;
                        n_state       = ST_REPORT;
                    end else if (i_status.stopped) begin
                        n_state = ST_REPORT;
                    end else begin
                        // Instruction fetch starts in the transfer cycle.
                        o_cmd.mem_sel = MS_PC;
                        o_cmd.mem_re  = 1'b1;
                        n_state       = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                o_cmd.mem_sel     = MS_DATA;
                o_cmd.latch_instr = 1'b1;
                if (i_status.is_store) begin
                    o_cmd.mem_we = 1'b1;
                end else begin
                    o_cmd.mem_re = 1'b1;
                end
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.report   = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the receiver takes it.
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/two_register_stack_cpu_core_unit.sv
// ----------------------------------------------------------------------------
// two_register_stack_cpu_core_unit
// Two-register stack processor with a 16384-word memory.
//
// Input stream: tuser selects the item kind (0 writes one memory word,
// 1 executes one instruction). tdata carries the write address and data.
// Output stream: one result per item with PC, SP, A, B, the executed opcode
// and the halt flag and cause, all as they stand after the item.
//
// After reset the memory is cleared one word a cycle; tready stays low until
// that pass is done. A write item is stored in its transfer cycle, then reported;
// a step runs through fetch, decode with the data access, and execute. The
// single memory port, used once by the fetch and once by the load or store,
// keeps these steps apart.
// Once halted, step items leave the state alone and report opcode 0, while
// write items still load memory.
// A finished result sits in the output register; the next item is accepted
// meanwhile and waits in its last cycle until the receiver takes the result.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_core_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [13:0] address, [45:14] data, [47:46] zero
    input  logic [47:0]  s_axis_tdata,
    // [0] op
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] pc, [63:32] sp, [95:64] acc_a, [127:96] acc_b,
    // [135:128] opcode_done, [136] halted, [139:137] halt_cause, [143:140] zero
    output logic [143:0] m_axis_tdata
);

    import trscc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic [31:0] w_pc, w_sp, w_a, w_b;
    logic [7:0]  w_opc;
    logic        w_halted;
    logic [2:0]  w_cause;

    trscc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    trscc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_wr_addr     (s_axis_tdata[13:0]),
        .i_wr_data     (s_axis_tdata[45:14]),
        .o_pc          (w_pc),
        .o_sp          (w_sp),
        .o_acc_a       (w_a),
        .o_acc_b       (w_b),
        .o_opcode_done (w_opc),
        .o_halted      (w_halted),
        .o_halt_cause  (w_cause)
    );

    // Result packing.
    assign m_axis_tdata = {4'b0000, w_cause, w_halted, w_opc, w_b, w_a, w_sp, w_pc};

endmodule

### rtl/core/trscc_checker.sv
// ----------------------------------------------------------------------------
// trscc_checker
// Port-level checks on the processor: clearing pass after reset, sticky
// halt state, consistency of the halt fields in each result and a stalled result holding.
// ----------------------------------------------------------------------------
module trscc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    import trscc_pkg::*;

    logic       r_seen_halt;
    logic [2:0] r_seen_cause;
    logic       w_out_xfer;
    logic       w_halt;
    logic [2:0] w_cause;

    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign w_halt     = m_axis_tdata[OUT_HALT_BIT];
    assign w_cause    = m_axis_tdata[OUT_CAUSE_LSB +: 3];

    // Remember the first halted result seen at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt  <= 1'b0;
            r_seen_cause <= CAUSE_NONE;
        end else if (w_out_xfer && w_halt && !r_seen_halt) begin
            r_seen_halt  <= 1'b1;
            r_seen_cause <= w_cause;
        end
    end

    // No transfer can be taken in the first cycle after reset: memory clears.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("input taken during memory clearing");

    // Halt flag and cause agree in every result.
    a_halt_cause_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_halt == (w_cause != CAUSE_NONE)))
        else $error("halt flag and cause disagree");

    // Once halted, every later result stays halted with the same cause.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && r_seen_halt) |-> (w_halt && w_cause == r_seen_cause))
        else $error("halt state changed without reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind two_register_stack_cpu_core_unit trscc_checker u_checker (.*);

### dv/tb_two_register_stack_cpu_core_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_register_stack_cpu_core_unit
// Self-checking bench for the two-register stack processor core. Items are
// queued together with the machine state they must produce. The state is
// worked out by a behavioral copy of the core kept in this file. A burst
// driver feeds the input stream. A stalling receiver takes the results,
// and a monitor checks every field. Programs are loaded and stepped one
// instruction at a time, so the core keeps running until a final stop is
// forced on purpose.
// ----------------------------------------------------------------------------
module tb_two_register_stack_cpu_core_unit;

    import trscc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int FIRST_PHASE    = 500;
    localparam int RANDOM_ITEMS   = 1000;

    // One input item and one result, as the core sees them.
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } t_core_item;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] sp;
        logic [31:0] acc_a;
        logic [31:0] acc_b;
        logic [7:0]  opc;
        logic        halted;
        logic [2:0]  cause;
    } t_core_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_PATTERN,
        RX_SPARSE,
        RX_HOLD
    } t_rx_mode;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [13:0] address, [45:14] data, [47:46] zero
    logic [47:0]  s_axis_tdata  = '0;
    // [0] op
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] pc, [63:32] sp, [95:64] acc_a, [127:96] acc_b,
    // [135:128] opcode_done, [136] halted, [139:137] halt_cause
    logic [143:0] m_axis_tdata;

    // Behavioral copy of the core state.
    logic [31:0]  cpu_mem [MEM_WORDS];
    logic [31:0]  cpu_pc;
    logic [31:0]  cpu_sp;
    logic [31:0]  cpu_a;
    logic [31:0]  cpu_b;
    logic         cpu_stopped;
    logic [2:0]   cpu_cause;

    t_core_item   pending_items[$];
    t_core_result expected_states[$];

    int unsigned  writes_queued = 0;
    int unsigned  steps_queued  = 0;
    int unsigned  steps_run     = 0;
    logic [255:0] opc_hit       = '0;
    int unsigned  results_seen  = 0;
    int unsigned  error_count   = 0;
    int unsigned  idle_cycles   = 0;
    int unsigned  burst_left    = 0;
    int unsigned  gap_left      = 0;
    int unsigned  rx_left       = 0;
    t_rx_mode     rx_mode       = RX_OPEN;
    logic [15:0]  rx_pattern    = '0;

    two_register_stack_cpu_core_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Put the behavioral copy into its post-reset state.
    task automatic reset_cpu();
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
        cpu_pc      = '0;
        cpu_sp      = MEM_WORDS - 1;
        cpu_a       = '0;
        cpu_b       = '0;
        cpu_stopped = 1'b0;
        cpu_cause   = CAUSE_NONE;
    endtask

    // Apply one item to the behavioral copy and return the state it leaves.
    function automatic t_core_result predict_item(input t_core_item it);
        t_core_result res;
        logic [31:0]  word;
        logic [31:0]  opr;
        logic [31:0]  ea;
        logic [7:0]   opc;
        logic [2:0]   cause;
        logic         branchy;
        res.opc = OPC_NONE;
        if (it.kind == ITEM_WRITE) begin
            cpu_mem[it.addr] = it.data;
        end else if (!cpu_stopped) begin
            // Addresses wrap by keeping the low bits of the 32-bit sum.
            word    = cpu_mem[cpu_pc[ADDR_W-1:0]];
            opc     = word[7:0];
            opr     = {{8{word[31]}}, word[31:8]};
            cause   = CAUSE_NONE;
            branchy = 1'b0;
            case (opc)
                OPC_LDC: begin
                    cpu_b = cpu_a;
                    cpu_a = opr;
                end
                OPC_ADC: cpu_a = cpu_a + opr;
                OPC_LDL: begin
                    ea    = cpu_sp + opr;
                    cpu_b = cpu_a;
                    cpu_a = cpu_mem[ea[ADDR_W-1:0]];
                end
                OPC_STL: begin
                    ea = cpu_sp + opr;
                    cpu_mem[ea[ADDR_W-1:0]] = cpu_a;
                    cpu_a = cpu_b;
                end
                OPC_LDNL: begin
                    ea    = cpu_a + opr;
                    cpu_a = cpu_mem[ea[ADDR_W-1:0]];
                end
                OPC_STNL: begin
                    ea = cpu_a + opr;
                    cpu_mem[ea[ADDR_W-1:0]] = cpu_b;
                end
                OPC_ADD:  cpu_a = cpu_a + cpu_b;
                OPC_SUB:  cpu_a = cpu_b - cpu_a;
                OPC_SHL:  cpu_a = cpu_b << cpu_a[4:0];
                OPC_SHR:  cpu_a = $signed(cpu_b) >>> cpu_a[4:0];
                OPC_ADJ:  cpu_sp = cpu_sp + opr;
                OPC_A2SP: begin
                    cpu_sp = cpu_a;
                    cpu_a  = cpu_b;
                end
                OPC_SP2A: begin
                    cpu_b = cpu_a;
                    cpu_a = cpu_sp;
                end
                OPC_CALL: begin
                    cpu_b   = cpu_a;
                    cpu_a   = cpu_pc;
                    cpu_pc  = cpu_pc + opr;
                    branchy = 1'b1;
                end
                OPC_RETURN: begin
                    if (cpu_pc == cpu_a && cpu_a == cpu_b) cause = CAUSE_SELFRET;
                    cpu_pc = cpu_a;
                    cpu_a  = cpu_b;
                end
                OPC_BRZ: begin
                    if (cpu_a == '0) cpu_pc = cpu_pc + opr;
                    branchy = 1'b1;
                end
                OPC_BRLZ: begin
                    if (cpu_a[31]) cpu_pc = cpu_pc + opr;
                    branchy = 1'b1;
                end
                OPC_BR: begin
                    cpu_pc  = cpu_pc + opr;
                    branchy = 1'b1;
                end
                OPC_HALT: cause = CAUSE_HALTOP;
                OPC_DATA, OPC_SET: ;
                default: cause = CAUSE_UNKNOWN;
            endcase
            // Stack overflow outranks a branch onto itself.
            if (cause == CAUSE_NONE && $signed(cpu_sp) >= int'(MEM_WORDS))
                cause = CAUSE_SPOVER;
            if (cause == CAUSE_NONE && branchy && opr == '1)
                cause = CAUSE_SELFLOOP;
            if (cause != CAUSE_NONE) begin
                cpu_stopped = 1'b1;
                cpu_cause   = cause;
            end else begin
                cpu_pc = cpu_pc + 1;
            end
            res.opc      = opc;
            opc_hit[opc] = 1'b1;
            steps_run++;
        end
        res.pc     = cpu_pc;
        res.sp     = cpu_sp;
        res.acc_a  = cpu_a;
        res.acc_b  = cpu_b;
        res.halted = cpu_stopped;
        res.cause  = cpu_cause;
        return res;
    endfunction

    // True when the instruction, run in the current state, leaves the core
    // running.
    function automatic bit keeps_running(input logic [7:0] opc, input logic [23:0] opr);
        logic [31:0] opr32;
        opr32 = {{8{opr[23]}}, opr};
        case (opc)
            OPC_HALT:   return 1'b0;
            OPC_ADJ:    return $signed(cpu_sp + opr32) < int'(MEM_WORDS);
            OPC_A2SP:   return $signed(cpu_a) < int'(MEM_WORDS);
            OPC_RETURN: return !(cpu_pc == cpu_a && cpu_a == cpu_b);
            OPC_CALL, OPC_BRZ, OPC_BRLZ, OPC_BR: return opr != '1;
            OPC_DATA, OPC_SET: return 1'b1;
            default:    return opc < OPC_HALT;
        endcase
    endfunction

    // Queue an item along with the state it must produce.
    task automatic queue_item(input logic kind, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data);
        t_core_item it;
        it.kind = kind;
        it.addr = addr;
        it.data = data;
        expected_states.insert(expected_states.size(), predict_item(it));
        pending_items.insert(pending_items.size(), it);
        if (kind == ITEM_WRITE) writes_queued++;
        else steps_queued++;
    endtask

    // Store an instruction at the current PC, then step it. The unused
    // fields of the step carry random bits.
    task automatic run_instr(input logic [7:0] opc, input logic [23:0] opr);
        queue_item(ITEM_WRITE, cpu_pc[ADDR_W-1:0], {opr, opc});
        queue_item(ITEM_STEP, ADDR_W'($urandom), $urandom);
    endtask

    function automatic logic [23:0] rand_operand();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2, 3:    return 24'($urandom);
            default: return 24'(int'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    // Any opcode that runs normally, the halt excluded.
    function automatic logic [7:0] pick_run_op();
        int unsigned pick;
        pick = $urandom_range(0, OPC_BR + 2);
        if (pick <= OPC_BR) return 8'(pick);
        else if (pick == OPC_BR + 1) return OPC_DATA;
        else return OPC_SET;
    endfunction

    // Extremes of the write fields, then every opcode but the halt, with a few edge
    // operands: wrapped stack and pointer addresses, shift amounts above 31,
    // taken and untaken branches, and a call that is returned from.
    task automatic load_directed();
        queue_item(ITEM_WRITE, '1, 32'h7FFF_FFFF);
        queue_item(ITEM_WRITE, ADDR_W'(14'h2AAA), 32'hAAAA_5555);
        queue_item(ITEM_WRITE, '0, {24'h80_0000, OPC_LDC});
        queue_item(ITEM_STEP, '1, '1);
        run_instr(OPC_LDC, 24'h7F_FFFF);
        run_instr(OPC_ADC, 24'h80_0000);
        run_instr(OPC_ADD, 24'd0);
        run_instr(OPC_SUB, 24'd0);
        run_instr(OPC_LDC, 24'd35);
        run_instr(OPC_SHL, 24'd0);
        run_instr(OPC_LDC, 24'(-8));
        run_instr(OPC_LDC, 24'd33);
        run_instr(OPC_SHR, 24'd0);
        run_instr(OPC_STL, 24'd7);
        run_instr(OPC_LDL, 24'd7);
        run_instr(OPC_LDC, 24'(-2));
        run_instr(OPC_STNL, 24'(-5));
        run_instr(OPC_LDNL, 24'(-5));
        run_instr(OPC_ADJ, 24'(-100));
        run_instr(OPC_SP2A, 24'd0);
        run_instr(OPC_A2SP, 24'd0);
        run_instr(OPC_CALL, 24'd3);
        run_instr(OPC_RETURN, 24'd0);
        run_instr(OPC_LDC, 24'd0);
        run_instr(OPC_BRZ, 24'd2);
        run_instr(OPC_BRLZ, 24'd5);
        run_instr(OPC_BR, 24'(-3));
        run_instr(OPC_DATA, 24'h12_3456);
        run_instr(OPC_SET, 24'hFE_DCBA);
    endtask

    // Mostly store-and-step pairs with random content; some steps run what
    // already sits at PC, and some writes land anywhere in memory.
    task automatic random_program(input int unsigned target);
        logic [7:0]  opc;
        logic [23:0] opr;
        logic [31:0] word;
        int unsigned pick;
        while (writes_queued + steps_queued < target) begin
            pick = $urandom_range(0, 99);
            word = cpu_mem[cpu_pc[ADDR_W-1:0]];
            if (pick < 10) begin
                queue_item(ITEM_WRITE, ADDR_W'($urandom), $urandom);
            end else if (pick < 18 && keeps_running(word[7:0], word[31:8])) begin
                queue_item(ITEM_STEP, ADDR_W'($urandom), $urandom);
            end else begin
                do begin
                    opc = pick_run_op();
                    opr = rand_operand();
                end while (!keeps_running(opc, opr));
                run_instr(opc, opr);
            end
        end
    endtask

    // Stop the core by one randomly chosen cause, then check that steps are
    // ignored while writes still reach memory.
    task automatic stop_machine();
        logic [2:0]  goal;
        logic [31:0] land;
        logic [7:0]  opc;
        goal = 3'($urandom_range(CAUSE_HALTOP, CAUSE_SELFLOOP));
        case (goal)
            CAUSE_HALTOP: run_instr(OPC_HALT, 24'($urandom));
            CAUSE_SELFRET: begin
                // Return to a known place, then make PC, A and B all equal.
                land = (cpu_pc == 32'd198) ? 32'd300 : 32'd200;
                run_instr(OPC_LDC, 24'(land - 1));
                run_instr(OPC_RETURN, 24'($urandom));
                run_instr(OPC_LDC, 24'(land + 2));
                run_instr(OPC_LDC, 24'(land + 2));
                run_instr(OPC_RETURN, 24'($urandom));
            end
            CAUSE_UNKNOWN:
                run_instr(8'($urandom_range(OPC_HALT + 1, OPC_SET - 1)), 24'($urandom));
            CAUSE_SPOVER: begin
                run_instr(OPC_LDC, 24'(MEM_WORDS + $urandom_range(0, 1000)));
                run_instr(OPC_A2SP, 24'($urandom));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       opc = OPC_CALL;
                    1:       opc = OPC_BRZ;
                    2:       opc = OPC_BRLZ;
                    default: opc = OPC_BR;
                endcase
                run_instr(opc, '1);
            end
        endcase
        repeat (12) begin
            if ($urandom_range(0, 1) == 0)
                queue_item(ITEM_STEP, ADDR_W'($urandom), $urandom);
            else
                queue_item(ITEM_WRITE, ADDR_W'($urandom), $urandom);
        end
    endtask

    // Wait until every queued item is taken and every result has come.
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_states.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: bursts of random length with random gaps, holding an offered
    // item until the transfer.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_items.delete(0);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // The offered item stays on the bus.
            end else if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, pending_items[0].data, pending_items[0].addr};
                s_axis_tuser  <= pending_items[0].kind;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, a rotating pattern, sparse
    // acceptance and a full stall.
    always @(posedge i_clk) begin : receiver
        logic ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                rx_left    = $urandom_range(4, 60);
                rx_pattern = 16'($urandom);
            end else begin
                rx_left--;
            end
            rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
            case (rx_mode)
                RX_OPEN:    ready_next = 1'b1;
                RX_PATTERN: ready_next = rx_pattern[0];
                RX_SPARSE:  ready_next = ($urandom_range(0, 3) == 0);
                default:    ready_next = 1'b0;
            endcase
            m_axis_tready <= ready_next;
        end
    end

    // Check each result transfer against the oldest expected state.
    always @(posedge i_clk) begin : monitor
        t_core_result got;
        t_core_result want;
        string        bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pc     = m_axis_tdata[OUT_PC_LSB +: WORD_W];
            got.sp     = m_axis_tdata[OUT_SP_LSB +: WORD_W];
            got.acc_a  = m_axis_tdata[OUT_A_LSB +: WORD_W];
            got.acc_b  = m_axis_tdata[OUT_B_LSB +: WORD_W];
            got.opc    = m_axis_tdata[OUT_OPC_LSB +: 8];
            got.halted = m_axis_tdata[OUT_HALT_BIT];
            got.cause  = m_axis_tdata[OUT_CAUSE_LSB +: 3];
            results_seen++;
            if (expected_states.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("Result %0d arrived with nothing expected: pc=%h", results_seen,
                             got.pc);
            end else begin
                want = expected_states.pop_front();
                bad  = "";
                if (got.pc !== want.pc)         bad = {bad, " pc"};
                if (got.sp !== want.sp)         bad = {bad, " sp"};
                if (got.acc_a !== want.acc_a)   bad = {bad, " acc_a"};
                if (got.acc_b !== want.acc_b)   bad = {bad, " acc_b"};
                if (got.opc !== want.opc)       bad = {bad, " opcode_done"};
                if (got.halted !== want.halted) bad = {bad, " halted"};
                if (got.cause !== want.cause)   bad = {bad, " halt_cause"};
                if (bad != "") begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d:%s", results_seen, bad);
                        $display("  expected pc=%h sp=%h a=%h b=%h opc=%h halted=%b cause=%0d",
                                 want.pc, want.sp, want.acc_a, want.acc_b, want.opc,
                                 want.halted, want.cause);
                        $display("  actual   pc=%h sp=%h a=%h b=%h opc=%h halted=%b cause=%0d",
                                 got.pc, got.sp, got.acc_a, got.acc_b, got.opc,
                                 got.halted, got.cause);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer at all.
    // The limit covers the memory clearing pass after reset.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_states.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence: directed part and first random phase, a full drain,
    // the second random phase, then the forced stop.
    initial begin
        reset_cpu();
        load_directed();
        random_program(FIRST_PHASE);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();
        random_program(RANDOM_ITEMS);
        stop_machine();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d memory writes and %0d steps, %0d executed, %0d distinct opcodes.",
                 writes_queued, steps_queued, steps_run, $countones(opc_hit));
        $display("Core stopped with halt cause %0d; %0d results checked, %0d mismatches.",
                 cpu_cause, results_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
